>>> rtl/core/vzc_pkg.sv
// vzc_pkg: shared types, constants and magic tables for the vz cassette image converter
// used by vzc_front, vzc_queue, vzc_back and vz_to_cassette_image_converter
package vzc_pkg;

    localparam int MAGIC_LEN = 4;
    localparam int NLEN_W    = 6;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h80;
    localparam logic [7:0] LEADIN_BYTE   = 8'hFE;
    localparam logic [7:0] LEADIN_LEN    = 8'd5;
    localparam logic [7:0] TAIL_BYTE     = 8'h00;
    localparam logic [7:0] MAGIC_A_HI    = 8'h20;
    localparam logic [7:0] MAGIC_A_LO    = 8'h00;

    typedef enum logic [1:0] {
        K_ONE,
        K_HEAD,
        K_ADDR,
        K_DEND
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         val;
        logic [7:0]         rep;
        logic               err;
        logic               last;
        logic [15:0]        w0;
        logic [15:0]        w1;
        logic [NLEN_W-1:0]  nlen;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] repeat_count;
        logic       format_error;
        logic       last_of_file;
    } t_res;

    function automatic logic [7:0] magic_a(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = MAGIC_A_HI;
            2'd1:    r = MAGIC_A_HI;
            default: r = MAGIC_A_LO;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] magic_b(input logic [1:0] idx);
        logic [7:0] r;
        case (idx)
            2'd0:    r = 8'h56;
            2'd1:    r = 8'h5a;
            2'd2:    r = 8'h46;
            default: r = 8'h30;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/core/vz_to_cassette_image_converter.sv
// vz_to_cassette_image_converter: vz file in, cassette image (byte, repeat) words out
// an input word's command is queued, then expanded into the output register
// throughput: one input word per cycle while the queue has room; the back part sends one
// output word per cycle while the output is ready; type bytes give 6 + name length words,
// address-high and last data bytes 4 words each; name bytes wait on an unfinished header
// reset: synchronous active-low, clears parser state, file length, queue and output valid
module vz_to_cassette_image_converter #(
    parameter int NAME_BYTES   = 17,
    parameter int PREAMBLE_LEN = 128,
    parameter int TAIL_LEN     = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [16:0] i_cfg_wdata,       // file_length
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,    // [7:0] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,    // [7:0] out_byte, [15:8] repeat_count
    output logic        o_m_axis_tuser,    // [0] format_error
    output logic        o_m_axis_tlast
);
    import vzc_pkg::*;

    localparam int NAW = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;

    logic           push, full, empty, pop, head_done;
    t_cmd           cmd_in, cmd_out;
    logic [NAW-1:0] name_addr;
    logic [7:0]     name_data;
    t_res           res;

    vzc_front #(
        .NAME_BYTES   (NAME_BYTES),
        .PREAMBLE_LEN (PREAMBLE_LEN),
        .TAIL_LEN     (TAIL_LEN),
        .NAW          (NAW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_byte      (i_s_axis_tdata),
        .o_push      (push),
        .o_cmd       (cmd_in),
        .i_full      (full),
        .i_head_done (head_done),
        .i_name_addr (name_addr),
        .o_name_data (name_data)
    );

    vzc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .i_pop   (pop),
        .o_cmd   (cmd_out),
        .o_full  (full),
        .o_empty (empty)
    );

    vzc_back #(
        .NAME_BYTES   (NAME_BYTES),
        .PREAMBLE_LEN (PREAMBLE_LEN),
        .TAIL_LEN     (TAIL_LEN),
        .NAW          (NAW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_head_done (head_done),
        .o_name_addr (name_addr),
        .i_name_data (name_data),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_res       (res)
    );

    assign o_m_axis_tdata = {res.repeat_count, res.out_byte};
    assign o_m_axis_tuser = res.format_error;
    assign o_m_axis_tlast = res.last_of_file;

endmodule

>>> rtl/core/vzc_front.sv
// vzc_front: parses the incoming file, holds header state and the name buffer
// issues at most one command per input word into the queue; depends on vzc_pkg
module vzc_front #(
    parameter int NAME_BYTES   = 17,
    parameter int PREAMBLE_LEN = 128,
    parameter int TAIL_LEN     = 20,
    parameter int NAW          = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wen,
    input  logic [16:0]           i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [7:0]            i_byte,
    output logic                  o_push,
    output vzc_pkg::t_cmd         o_cmd,
    input  logic                  i_full,
    input  logic                  i_head_done,
    input  logic [NAW-1:0]        i_name_addr,
    output logic [7:0]            o_name_data
);
    import vzc_pkg::*;

    localparam int TYPE_POS = MAGIC_LEN + NAME_BYTES;
    localparam int SLO_POS  = TYPE_POS + 1;
    localparam int SHI_POS  = TYPE_POS + 2;
    localparam int DATA_POS = TYPE_POS + 3;
    localparam int NLW      = $clog2(NAME_BYTES + 1);
    localparam logic [15:0] LEN_BASE  = 16'(PREAMBLE_LEN + 12 + TAIL_LEN);
    localparam logic [7:0]  WAIT_BASE = 8'(PREAMBLE_LEN + 9);

    logic [16:0]    r_file_length;
    logic [15:0]    r_prog_len;
    logic [16:0]    r_pos, n_pos;
    logic [NLW-1:0] r_name_len, n_name_len;
    logic           r_nul, n_nul;
    logic [1:0]     r_flags, n_flags;
    logic [15:0]    r_start, n_start;
    logic [15:0]    r_sum, n_sum;
    logic           r_discard, n_discard;
    logic           r_name_busy, n_name_busy;
    logic [7:0]     r_name [NAME_BYTES];

    logic        accept, is_last, in_name, restart, name_we, bad;
    logic [16:0] pos1, name_off;
    logic [1:0]  flags_new;
    logic [15:0] start_full, end_addr, sum_data;
    t_cmd        cmd;

    assign in_name  = (r_pos >= 17'(MAGIC_LEN)) && (r_pos < 17'(TYPE_POS));
    assign o_ready  = !i_full && !(r_name_busy && in_name);
    assign accept   = i_valid && o_ready;
    assign pos1     = r_pos + 17'd1;
    assign is_last  = ({1'b0, r_pos} + 18'd1) >= {1'b0, r_file_length};
    assign name_off = r_pos - 17'(MAGIC_LEN);
    assign flags_new = {r_flags[1] & (i_byte == magic_b(r_pos[1:0])),
                        r_flags[0] & (i_byte == magic_a(r_pos[1:0]))};
    assign start_full = {i_byte, r_start[7:0]};
    assign end_addr   = start_full + r_prog_len;
    assign sum_data   = r_sum + 16'(i_byte);
    assign o_name_data = r_name[i_name_addr];
    assign o_cmd = cmd;

    always_comb begin
        n_pos       = r_pos;
        n_name_len  = r_name_len;
        n_nul       = r_nul;
        n_flags     = r_flags;
        n_start     = r_start;
        n_sum       = r_sum;
        n_discard   = r_discard;
        n_name_busy = r_name_busy;
        restart     = 1'b0;
        name_we     = 1'b0;
        bad         = 1'b0;
        o_push      = 1'b0;
        cmd         = '0;
        cmd.kind    = K_ONE;
        cmd.rep     = 8'd1;
        if (i_head_done) begin
            n_name_busy = 1'b0;
        end
        if (accept) begin
            if (r_discard) begin
                if (is_last) begin
                    restart = 1'b1;
                end else begin
                    n_pos = pos1;
                end
            end else if (r_pos < 17'(MAGIC_LEN)) begin
                bad = ((r_pos == '0) && (r_file_length <= 17'(DATA_POS)))
                      || (flags_new == 2'b00);
                if (bad) begin
                    o_push     = 1'b1;
                    cmd.val    = 8'd0;
                    cmd.rep    = 8'd0;
                    cmd.err    = 1'b1;
                    cmd.last   = 1'b1;
                    if (is_last) begin
                        restart = 1'b1;
                    end else begin
                        n_discard = 1'b1;
                        n_pos     = pos1;
                    end
                end else begin
                    n_flags = flags_new;
                    n_pos   = pos1;
                end
            end else if (r_pos < 17'(TYPE_POS)) begin
                name_we = 1'b1;
                if (!r_nul) begin
                    n_name_len = r_name_len + NLW'(1);
                    if (i_byte == 8'd0) begin
                        n_nul = 1'b1;
                    end
                end
                n_pos = pos1;
            end else if (r_pos == 17'(TYPE_POS)) begin
                o_push      = 1'b1;
                cmd.kind    = K_HEAD;
                cmd.val     = i_byte;
                cmd.w0      = LEN_BASE + 16'(r_name_len) + r_prog_len;
                cmd.w1      = {8'd0, WAIT_BASE + 8'(r_name_len)};
                cmd.nlen    = NLEN_W'(r_name_len);
                n_name_busy = 1'b1;
                n_pos       = pos1;
            end else if (r_pos == 17'(SLO_POS)) begin
                n_start = {8'd0, i_byte};
                n_sum   = sum_data;
                n_pos   = pos1;
            end else if (r_pos == 17'(SHI_POS)) begin
                o_push   = 1'b1;
                cmd.kind = K_ADDR;
                cmd.w0   = start_full;
                cmd.w1   = end_addr;
                n_start  = start_full;
                n_sum    = sum_data + 16'(end_addr[7:0]) + 16'(end_addr[15:8]);
                n_pos    = pos1;
            end else begin
                o_push  = 1'b1;
                cmd.val = i_byte;
                if (is_last) begin
                    cmd.kind = K_DEND;
                    cmd.w0   = sum_data;
                    restart  = 1'b1;
                end else begin
                    n_sum = sum_data;
                    n_pos = pos1;
                end
            end
        end
        if (restart) begin
            n_pos      = '0;
            n_name_len = '0;
            n_nul      = 1'b0;
            n_flags    = 2'b11;
            n_start    = '0;
            n_sum      = '0;
            n_discard  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_file_length <= '0;
            r_prog_len    <= 16'(17'd0 - 17'(DATA_POS));
            r_pos         <= '0;
            r_name_len    <= '0;
            r_nul         <= 1'b0;
            r_flags       <= 2'b11;
            r_start       <= '0;
            r_sum         <= '0;
            r_discard     <= 1'b0;
            r_name_busy   <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_file_length <= i_cfg_wdata;
                r_prog_len    <= 16'(i_cfg_wdata - 17'(DATA_POS));
            end
            r_pos       <= n_pos;
            r_name_len  <= n_name_len;
            r_nul       <= n_nul;
            r_flags     <= n_flags;
            r_start     <= n_start;
            r_sum       <= n_sum;
            r_discard   <= n_discard;
            r_name_busy <= n_name_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (name_we) begin
            r_name[name_off[NAW-1:0]] <= i_byte;
        end
    end

endmodule

>>> rtl/core/vzc_queue.sv
// vzc_queue: short command queue between the front and back parts
// depends on vzc_pkg
module vzc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  vzc_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output vzc_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import vzc_pkg::*;

    t_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_AW+1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (Q_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> rtl/core/vzc_back.sv
// vzc_back: expands queued commands into (byte, repeat) output words
// holds the output register; reads the name buffer in vzc_front; depends on vzc_pkg
module vzc_back #(
    parameter int NAME_BYTES   = 17,
    parameter int PREAMBLE_LEN = 128,
    parameter int TAIL_LEN     = 20,
    parameter int NAW          = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  vzc_pkg::t_cmd  i_cmd,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_head_done,
    output logic [NAW-1:0] o_name_addr,
    input  logic [7:0]     i_name_data,
    output logic           o_valid,
    input  logic           i_ready,
    output vzc_pkg::t_res  o_res
);
    import vzc_pkg::*;

    localparam int SW = $clog2(NAME_BYTES + 6);
    localparam logic [SW-1:0] HS_LEN_LO = SW'(0);
    localparam logic [SW-1:0] HS_LEN_HI = SW'(1);
    localparam logic [SW-1:0] HS_WAIT   = SW'(2);
    localparam logic [SW-1:0] HS_PRE    = SW'(3);
    localparam logic [SW-1:0] HS_LEADIN = SW'(4);
    localparam logic [SW-1:0] HS_TYPE   = SW'(5);
    localparam logic [SW-1:0] HS_NAME   = SW'(6);

    logic [SW-1:0] r_step;
    logic          r_valid;
    t_res          r_res;
    t_res          res;
    logic          final_step, advance;
    logic [SW-1:0] name_idx;

    assign advance     = !i_empty && (!r_valid || i_ready);
    assign o_pop       = advance && final_step;
    assign o_head_done = o_pop && (i_cmd.kind == K_HEAD);
    assign name_idx    = r_step - HS_NAME;
    assign o_name_addr = name_idx[NAW-1:0];
    assign o_valid     = r_valid;
    assign o_res       = r_res;

    always_comb begin
        res              = '0;
        res.repeat_count = 8'd1;
        final_step       = 1'b0;
        case (i_cmd.kind)
            K_ONE: begin
                res.out_byte     = i_cmd.val;
                res.repeat_count = i_cmd.rep;
                res.format_error = i_cmd.err;
                res.last_of_file = i_cmd.last;
                final_step       = 1'b1;
            end
            K_HEAD: begin
                case (r_step)
                    HS_LEN_LO: res.out_byte = i_cmd.w0[7:0];
                    HS_LEN_HI: res.out_byte = i_cmd.w0[15:8];
                    HS_WAIT:   res.out_byte = i_cmd.w1[7:0];
                    HS_PRE: begin
                        res.out_byte     = PREAMBLE_BYTE;
                        res.repeat_count = 8'(PREAMBLE_LEN);
                    end
                    HS_LEADIN: begin
                        res.out_byte     = LEADIN_BYTE;
                        res.repeat_count = LEADIN_LEN;
                    end
                    HS_TYPE:   res.out_byte = i_cmd.val;
                    default:   res.out_byte = i_name_data;
                endcase
                final_step = (7'(r_step) == 7'(HS_TYPE) + 7'(i_cmd.nlen));
            end
            K_ADDR: begin
                case (r_step[1:0])
                    2'd0:    res.out_byte = i_cmd.w0[7:0];
                    2'd1:    res.out_byte = i_cmd.w0[15:8];
                    2'd2:    res.out_byte = i_cmd.w1[7:0];
                    default: res.out_byte = i_cmd.w1[15:8];
                endcase
                final_step = (r_step == SW'(3));
            end
            K_DEND: begin
                case (r_step[1:0])
                    2'd0:    res.out_byte = i_cmd.val;
                    2'd1:    res.out_byte = i_cmd.w0[7:0];
                    2'd2:    res.out_byte = i_cmd.w0[15:8];
                    default: begin
                        res.out_byte     = TAIL_BYTE;
                        res.repeat_count = 8'(TAIL_LEN);
                        res.last_of_file = 1'b1;
                    end
                endcase
                final_step = (r_step == SW'(3));
            end
            default: begin
                final_step = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valid <= 1'b1;
                if (final_step) begin
                    r_step <= '0;
                end else begin
                    r_step <= r_step + SW'(1);
                end
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= res;
        end
    end

endmodule

>>> tb/vz_to_cassette_image_converter_test.sv
`timescale 1ns / 100ps
// vz_to_cassette_image_converter_test: self-checking testbench for the vz to cassette converter
// streams vz files in, predicts the (byte, repeat) image words and checks them in order
// depends on vzc_pkg and vz_to_cassette_image_converter
module vz_to_cassette_image_converter_test;

    localparam int NAME_BYTES    = 17;
    localparam int PREAMBLE_LEN  = 128;
    localparam int TAIL_LEN      = 20;
    localparam int MAGIC_LEN     = vzc_pkg::MAGIC_LEN;
    localparam int TYPE_POS      = MAGIC_LEN + NAME_BYTES;
    localparam int DATA_POS      = TYPE_POS + 3;
    localparam int IDLE_PCT      = 12;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [31:0] MAGIC_A     = 32'h0000_2020;
    localparam logic [31:0] MAGIC_B     = 32'h3046_5a56;
    localparam logic [7:0]  SYNC_BYTE   = 8'h80;
    localparam logic [7:0]  LEAD_BYTE   = 8'hFE;
    localparam logic [7:0]  LEAD_COUNT  = 8'd5;
    localparam logic [7:0]  PAD_BYTE    = 8'h00;
    localparam logic [17:0] ERR_WORD    = {8'h00, 8'h00, 1'b1, 1'b1};

    typedef struct packed {
        logic          set_len;
        logic [16:0]   len;
        logic [7:0]    data;
        logic          typed;
        vzc_pkg::t_res want;
    } t_dir_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wen       = 1'b0;
    logic [16:0] i_cfg_wdata     = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata  = '0;   // [7:0] data_byte
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [15:0] o_m_axis_tdata;         // [7:0] out_byte, [15:8] repeat_count
    logic        o_m_axis_tuser;         // [0] format_error
    logic        o_m_axis_tlast;

    bit            idle_on = 1'b1;
    int            bad_words = 0;
    vzc_pkg::t_res pending_image[$];
    t_dir_row      dir_rows[$];
    vzc_pkg::t_res got_word;
    vzc_pkg::t_res want_word;

    // parser state of the predictor
    logic [16:0] vz_len;
    logic [16:0] vz_pos;
    logic [7:0]  vz_name [0:NAME_BYTES-1];
    logic [4:0]  vz_name_len;
    logic        vz_nul_seen;
    logic [1:0]  vz_magic_ok;
    logic [15:0] vz_load_addr;
    logic [15:0] vz_sum;
    logic        vz_skipping;

    vz_to_cassette_image_converter #(
        .NAME_BYTES   (NAME_BYTES),
        .PREAMBLE_LEN (PREAMBLE_LEN),
        .TAIL_LEN     (TAIL_LEN)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wen       (i_cfg_wen),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic start_new_file();
        int i;
        vz_pos       = '0;
        for (i = 0; i < NAME_BYTES; i++) vz_name[i] = 8'h00;
        vz_name_len  = '0;
        vz_nul_seen  = 1'b0;
        vz_magic_ok  = 2'b11;
        vz_load_addr = '0;
        vz_sum       = '0;
        vz_skipping  = 1'b0;
    endtask

    task automatic queue_word(input logic [7:0] val, input logic [7:0] rep,
                              input logic err, input logic fin);
        vzc_pkg::t_res w;
        w.out_byte     = val;
        w.repeat_count = rep;
        w.format_error = err;
        w.last_of_file = fin;
        pending_image.push_back(w);
    endtask

    // image words caused by one file byte
    task automatic convert_byte(input logic [7:0] b);
        logic        at_end;
        logic        bad;
        logic [15:0] prog;
        logic [15:0] img_len;
        logic [15:0] end_addr;
        logic [7:0]  wait_byte;
        int          i;
        at_end = ({1'b0, vz_pos} + 18'd1) >= {1'b0, vz_len};
        prog   = 16'(vz_len - 17'(DATA_POS));
        if (vz_skipping) begin
            if (at_end) start_new_file();
            else vz_pos++;
        end else if (vz_pos < MAGIC_LEN) begin
            bad = (vz_pos == 0) && (vz_len <= 17'(DATA_POS));
            if (b != MAGIC_A[8*vz_pos +: 8]) vz_magic_ok[0] = 1'b0;
            if (b != MAGIC_B[8*vz_pos +: 8]) vz_magic_ok[1] = 1'b0;
            if (vz_magic_ok == 2'b00) bad = 1'b1;
            if (bad) begin
                queue_word(8'h00, 8'h00, 1'b1, 1'b1);
                if (at_end) begin
                    start_new_file();
                end else begin
                    vz_skipping = 1'b1;
                    vz_pos++;
                end
            end else begin
                vz_pos++;
            end
        end else if (vz_pos < TYPE_POS) begin
            vz_name[vz_pos - MAGIC_LEN] = b;
            if (!vz_nul_seen) begin
                vz_name_len++;
                if (b == 8'h00) vz_nul_seen = 1'b1;
            end
            vz_pos++;
        end else if (vz_pos == TYPE_POS) begin
            img_len   = 16'(PREAMBLE_LEN + vz_name_len + prog + 12 + TAIL_LEN);
            wait_byte = 8'(PREAMBLE_LEN + vz_name_len + 9);
            queue_word(img_len[7:0], 8'd1, 1'b0, 1'b0);
            queue_word(img_len[15:8], 8'd1, 1'b0, 1'b0);
            queue_word(wait_byte, 8'd1, 1'b0, 1'b0);
            queue_word(SYNC_BYTE, 8'(PREAMBLE_LEN), 1'b0, 1'b0);
            queue_word(LEAD_BYTE, LEAD_COUNT, 1'b0, 1'b0);
            queue_word(b, 8'd1, 1'b0, 1'b0);
            for (i = 0; i < vz_name_len; i++) queue_word(vz_name[i], 8'd1, 1'b0, 1'b0);
            vz_pos++;
        end else if (vz_pos == TYPE_POS + 1) begin
            vz_load_addr = {8'h00, b};
            vz_sum       = vz_sum + b;
            vz_pos++;
        end else if (vz_pos == TYPE_POS + 2) begin
            vz_load_addr[15:8] = b;
            end_addr = vz_load_addr + prog;
            vz_sum   = vz_sum + b + end_addr[7:0] + end_addr[15:8];
            queue_word(vz_load_addr[7:0], 8'd1, 1'b0, 1'b0);
            queue_word(b, 8'd1, 1'b0, 1'b0);
            queue_word(end_addr[7:0], 8'd1, 1'b0, 1'b0);
            queue_word(end_addr[15:8], 8'd1, 1'b0, 1'b0);
            vz_pos++;
        end else begin
            vz_sum = vz_sum + b;
            queue_word(b, 8'd1, 1'b0, 1'b0);
            if (at_end) begin
                queue_word(vz_sum[7:0], 8'd1, 1'b0, 1'b0);
                queue_word(vz_sum[15:8], 8'd1, 1'b0, 1'b0);
                queue_word(PAD_BYTE, 8'(TAIL_LEN), 1'b0, 1'b1);
                start_new_file();
            end else begin
                vz_pos++;
            end
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input bit typed, input vzc_pkg::t_res typed_word);
        while (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (typed) pending_image.push_back(typed_word);
        else convert_byte(b);
    endtask

    // let the image drain and the back end go quiet
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_image.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_file_length(input logic [16:0] v);
        settle();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        vz_len = v;
        i_cfg_wen <= 1'b0;
    endtask

    // one file of flen bytes; tiny lengths send a few one-byte files
    task automatic send_vz_file(input logic [16:0] flen, input bit corrupt, output int sent);
        int unsigned n;
        int unsigned i;
        int unsigned bad_at;
        int unsigned nul_at;
        bit          form_b;
        logic [7:0]  b;
        form_b = 1'($urandom_range(1));
        nul_at = $urandom_range(20);
        bad_at = corrupt ? $urandom_range(3) : MAGIC_LEN;
        n      = (flen <= 1) ? $urandom_range(1, 3) : flen;
        for (i = 0; i < n; i++) begin
            if (i < MAGIC_LEN) begin
                b = form_b ? MAGIC_B[8*i +: 8] : MAGIC_A[8*i +: 8];
                if (i == bad_at) b = b ^ (8'h01 << $urandom_range(7));
            end else if (i < TYPE_POS) begin
                if (i - MAGIC_LEN == nul_at) b = 8'h00;
                else if (i - MAGIC_LEN < nul_at) b = 8'($urandom_range(1, 255));
                else b = 8'($urandom_range(255));
            end else begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, 1'b0, '0);
        end
        sent = n;
    endtask

    task automatic add_len(input logic [16:0] v);
        t_dir_row r;
        r = '0;
        r.set_len = 1'b1;
        r.len = v;
        dir_rows.push_back(r);
    endtask

    task automatic add_byte(input logic [7:0] b, input bit typed);
        t_dir_row r;
        r = '0;
        r.data  = b;
        r.typed = typed;
        r.want  = typed ? ERR_WORD : '0;
        dir_rows.push_back(r);
    endtask

    always @(posedge i_clk) begin
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            got_word = {o_m_axis_tdata[7:0], o_m_axis_tdata[15:8],
                        o_m_axis_tuser, o_m_axis_tlast};
            if (pending_image.size() == 0) begin
                if (bad_words < 10)
                    $display("unexpected word: byte %02h rep %0d err %0b last %0b",
                             got_word.out_byte, got_word.repeat_count,
                             got_word.format_error, got_word.last_of_file);
                bad_words++;
            end else begin
                want_word = pending_image.pop_front();
                if (got_word.out_byte !== want_word.out_byte ||
                    got_word.repeat_count !== want_word.repeat_count ||
                    got_word.format_error !== want_word.format_error ||
                    got_word.last_of_file !== want_word.last_of_file) begin
                    if (bad_words < 10)
                        $display("mismatch: want byte %02h rep %0d err %0b last %0b,",
                                 want_word.out_byte, want_word.repeat_count,
                                 want_word.format_error, want_word.last_of_file,
                                 " got byte %02h rep %0d err %0b last %0b",
                                 got_word.out_byte, got_word.repeat_count,
                                 got_word.format_error, got_word.last_of_file);
                    bad_words++;
                end
            end
        end
        i_m_axis_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end

    initial begin
        #10ms;
        $display("vz_to_cassette_image_converter verification failed");
        $finish;
    end

    initial begin
        t_dir_row    row;
        logic [16:0] next_len;
        int          sent;
        int          file_no;
        int          rand_items;
        int          i;
        vz_len = '0;
        start_new_file();

        // length register at reset, then set to 1: every byte is a one-byte bad file
        add_byte(8'h20, 1'b1);
        add_byte(8'hFF, 1'b1);
        add_len(17'd1);
        add_byte(8'h00, 1'b1);
        // shortest valid file: one data byte, name "A"
        add_len(17'd25);
        add_byte(8'h56, 1'b0);
        add_byte(8'h5a, 1'b0);
        add_byte(8'h46, 1'b0);
        add_byte(8'h30, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h00, 1'b0);
        for (i = 0; i < NAME_BYTES - 2; i++) add_byte(8'hFF, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'h00, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hC9, 1'b0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        while (dir_rows.size() != 0) begin
            row = dir_rows.pop_front();
            if (row.set_len) set_file_length(row.len);
            else send_byte(row.data, row.typed, row.want);
        end

        file_no    = 0;
        rand_items = 0;
        while (rand_items < 400) begin
            idle_on = (file_no < 4) || (file_no > 8);
            if ($urandom_range(99) < 35) begin
                next_len = vz_len;
            end else begin
                i = $urandom_range(99);
                if (i < 72) next_len = 17'(DATA_POS + 1 + $urandom_range(40));
                else if (i < 88) next_len = 17'($urandom_range(2, DATA_POS));
                else next_len = 17'($urandom_range(1));
            end
            if (next_len != vz_len) set_file_length(next_len);
            send_vz_file(next_len, (next_len > DATA_POS) && ($urandom_range(99) < 20), sent);
            rand_items += sent;
            file_no++;
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (bad_words == 0)
            $display("vz_to_cassette_image_converter verification clean");
        else
            $display("vz_to_cassette_image_converter verification failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/vzc_pkg.sv
rtl/core/vzc_front.sv
rtl/core/vzc_queue.sv
rtl/core/vzc_back.sv
rtl/core/vz_to_cassette_image_converter.sv
tb/vz_to_cassette_image_converter_test.sv
